[sv/ffha_pkg.sv]
// Shared types and constants for the first-fit heap allocator.
// Depends on nothing; the engine and core files refer to it by scoped names.
`default_nettype none

package ffha_pkg;

   // Heap geometry.
   localparam int HEAP_UNITS   = 4096;
   localparam int ADDR_W       = 12;
   localparam int UNIT_W       = 13;
   localparam int NEED_W       = 14;
   localparam int BYTES_W      = 16;
   localparam int HEADER_BYTES = 8;
   localparam int HDR_SHIFT    = 3;
   localparam int WALK_LIMIT   = HEAP_UNITS + 2;

   // The sentinel node code lies above every heap unit.
   localparam logic [UNIT_W-1:0] SENT      = UNIT_W'(HEAP_UNITS);
   localparam logic [UNIT_W-1:0] POOL_MIN  = UNIT_W'(2);
   localparam logic [UNIT_W-1:0] POOL_MAX  = UNIT_W'(HEAP_UNITS);

   // Request operation codes.
   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_MEM   = 2'd1,
      ST_UNMARKED = 2'd2
   } status_type;

   // One free-list header: link to the next free block and block size.
   typedef struct packed {
      logic [UNIT_W-1:0] link;
      logic [UNIT_W-1:0] size;
   } node_type;

   // Result of one item handed from the engine to the output register.
   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] granted;
      logic [UNIT_W-1:0] units;
   } result_type;

endpackage

`default_nettype wire

[sv/ffha_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none

module ffha_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 26
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; rd_data is registered and valid in the cycle after rd_en.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[sv/ffha_engine.sv]
// Free-list walker: the header memory, the allocated-mark memory and the
// sequencer that searches, splits, inserts and merges. Depends on ffha_pkg, ffha_ram.
`default_nettype none

module ffha_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          reinit,
   input  wire logic [ffha_pkg::UNIT_W-1:0]   pool_units,
   input  wire logic                          start,
   input  wire logic                          op,
   input  wire logic [ffha_pkg::BYTES_W-1:0]  request_bytes,
   input  wire logic [ffha_pkg::ADDR_W-1:0]   block_addr,
   input  wire logic                          out_free,
   output logic                               idle,
   output logic                               done,
   output ffha_pkg::result_type               result
);

   typedef enum logic [11:0] {
      S_CLEAR  = 12'b0000_0000_0001,
      S_IDLE   = 12'b0000_0000_0010,
      S_AROV   = 12'b0000_0000_0100,
      S_ARD    = 12'b0000_0000_1000,
      S_ACHK   = 12'b0000_0001_0000,
      S_ASPLIT = 12'b0000_0010_0000,
      S_RMARK  = 12'b0000_0100_0000,
      S_RRD    = 12'b0000_1000_0000,
      S_RCHK   = 12'b0001_0000_0000,
      S_RPN    = 12'b0010_0000_0000,
      S_RLO    = 12'b0100_0000_0000,
      S_DONE   = 12'b1000_0000_0000
   } state_type;

   localparam int AW = ffha_pkg::ADDR_W;
   localparam int UW = ffha_pkg::UNIT_W;
   localparam int NW = ffha_pkg::NEED_W;

   state_type             state_ff, state_in;
   logic [UW-1:0]         p_ff, p_in;
   logic [UW-1:0]         prev_ff, prev_in;
   logic [UW-1:0]         prev_sz_ff, prev_sz_in;
   logic [UW-1:0]         psz_ff, psz_in;
   logic [UW-1:0]         pn_ff, pn_in;
   logic [UW-1:0]         bsz_ff, bsz_in;
   logic [NW-1:0]         need_ff, need_in;
   logic [AW-1:0]         bp_ff, bp_in;
   logic [AW-1:0]         q_ff, q_in;
   logic [UW-1:0]         steps_ff, steps_in;
   logic [UW-1:0]         rover_ff, rover_in;
   logic [UW-1:0]         sent_ff, sent_in;
   logic [UW-1:0]         units_ff, units_in;
   logic [AW-1:0]         clr_ff, clr_in;
   ffha_pkg::status_type  status_ff, status_in;
   logic [AW-1:0]         granted_ff, granted_in;

   // Memory ports.
   logic                  node_we, node_re, mark_we, mark_re, mark_wd, mark_q;
   logic [AW-1:0]         node_wa, node_ra, mark_wa, mark_ra;
   ffha_pkg::node_type    node_wd, node_q;

   // Derived values.
   logic [UW-1:0]         cur_sz, cur_link, rem, q_full;
   logic [UW-1:0]         bp13;
   logic [16:0]           round_sum;
   logic                  walk_end, fit, merge_hi, merge_lo;

   ffha_ram #(.ADDR_W(AW), .DATA_W(2*UW)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_wa),
      .wr_data (node_wd),
      .rd_en   (node_re),
      .rd_addr (node_ra),
      .rd_data (node_q)
   );

   ffha_ram #(.ADDR_W(AW), .DATA_W(1)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_wa),
      .wr_data (mark_wd),
      .rd_en   (mark_re),
      .rd_addr (mark_ra),
      .rd_data (mark_q)
   );

   // The sentinel has size zero and its link lives in a register.
   assign cur_sz    = (p_ff == ffha_pkg::SENT) ? '0 : node_q.size;
   assign cur_link  = (p_ff == ffha_pkg::SENT) ? sent_ff : node_q.link;
   assign rem       = cur_sz - need_ff[UW-1:0];
   assign q_full    = p_ff + rem;
   assign bp13      = {1'b0, bp_ff};
   assign round_sum = {1'b0, request_bytes} + 17'(ffha_pkg::HEADER_BYTES - 1);
   assign walk_end  = (steps_ff == UW'(ffha_pkg::WALK_LIMIT));
   assign fit       = (p_ff != ffha_pkg::SENT) && ({1'b0, cur_sz} >= need_ff);
   assign merge_hi  = (pn_ff != ffha_pkg::SENT) &&
                      (({1'b0, bp13} + {1'b0, bsz_ff}) == {1'b0, pn_ff});
   assign merge_lo  = (p_ff != ffha_pkg::SENT) &&
                      (({1'b0, p_ff} + {1'b0, psz_ff}) == {1'b0, bp13});

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      p_in       = p_ff;
      prev_in    = prev_ff;
      prev_sz_in = prev_sz_ff;
      psz_in     = psz_ff;
      pn_in      = pn_ff;
      bsz_in     = bsz_ff;
      need_in    = need_ff;
      bp_in      = bp_ff;
      q_in       = q_ff;
      steps_in   = steps_ff;
      rover_in   = rover_ff;
      sent_in    = sent_ff;
      units_in   = units_ff;
      clr_in     = clr_ff;
      status_in  = status_ff;
      granted_in = granted_ff;
      node_we    = 1'b0;
      node_wa    = '0;
      node_wd    = '0;
      node_re    = 1'b0;
      node_ra    = '0;
      mark_we    = 1'b0;
      mark_wa    = '0;
      mark_wd    = 1'b0;
      mark_re    = 1'b0;
      mark_ra    = '0;

      case (state_ff)
         // Clear every mark and lay down one free block at unit 0.
         S_CLEAR: begin
            mark_we      = 1'b1;
            mark_wa      = clr_ff;
            node_we      = 1'b1;
            node_wd.link = ffha_pkg::SENT;
            node_wd.size = pool_units;
            clr_in       = clr_ff + AW'(1);
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            steps_in   = '0;
            granted_in = '0;
            status_in  = ffha_pkg::ST_OK;
            if (start) begin
               if (op == ffha_pkg::OP_ALLOC) begin
                  need_in = NW'(round_sum >> ffha_pkg::HDR_SHIFT) + NW'(1);
                  prev_in = rover_ff;
                  if (rover_ff == ffha_pkg::SENT) begin
                     prev_sz_in = '0;
                     p_in       = sent_ff;
                     state_in   = S_ARD;
                  end else begin
                     node_re  = 1'b1;
                     node_ra  = rover_ff[AW-1:0];
                     state_in = S_AROV;
                  end
               end else begin
                  bp_in    = block_addr - AW'(1);
                  node_re  = 1'b1;
                  node_ra  = block_addr - AW'(1);
                  mark_re  = 1'b1;
                  mark_ra  = block_addr - AW'(1);
                  state_in = S_RMARK;
               end
            end
         end

         // The rover's header gives the first candidate.
         S_AROV: begin
            prev_sz_in = node_q.size;
            p_in       = node_q.link;
            state_in   = S_ARD;
         end

         S_ARD: begin
            node_re  = 1'b1;
            node_ra  = p_ff[AW-1:0];
            state_in = S_ACHK;
         end

         // First-fit test on the current node.
         S_ACHK: begin
            if (walk_end) begin
               status_in = ffha_pkg::ST_NO_MEM;
               state_in  = S_DONE;
            end else if (fit) begin
               rover_in = prev_ff;
               units_in = units_ff + need_ff[UW-1:0];
               if ({1'b0, cur_sz} == need_ff) begin
                  // Exact fit: unlink the block.
                  if (prev_ff == ffha_pkg::SENT) begin
                     sent_in = cur_link;
                  end else begin
                     node_we      = 1'b1;
                     node_wa      = prev_ff[AW-1:0];
                     node_wd.link = cur_link;
                     node_wd.size = prev_sz_ff;
                  end
                  mark_we    = 1'b1;
                  mark_wa    = p_ff[AW-1:0];
                  mark_wd    = 1'b1;
                  granted_in = p_ff[AW-1:0] + AW'(1);
                  state_in   = S_DONE;
               end else begin
                  // Larger block: shrink it and hand out its tail.
                  node_we      = 1'b1;
                  node_wa      = p_ff[AW-1:0];
                  node_wd.link = cur_link;
                  node_wd.size = rem;
                  q_in         = q_full[AW-1:0];
                  state_in     = S_ASPLIT;
               end
            end else if (p_ff == rover_ff) begin
               status_in = ffha_pkg::ST_NO_MEM;
               state_in  = S_DONE;
            end else begin
               prev_in    = p_ff;
               prev_sz_in = cur_sz;
               p_in       = cur_link;
               steps_in   = steps_ff + UW'(1);
               state_in   = S_ARD;
            end
         end

         // Write the header of the tail block that was granted.
         S_ASPLIT: begin
            node_we      = 1'b1;
            node_wa      = q_ff;
            node_wd.link = '0;
            node_wd.size = need_ff[UW-1:0];
            mark_we      = 1'b1;
            mark_wa      = q_ff;
            mark_wd      = 1'b1;
            granted_in   = q_ff + AW'(1);
            state_in     = S_DONE;
         end

         // The block must carry the allocated mark to be released.
         S_RMARK: begin
            if (!mark_q) begin
               status_in = ffha_pkg::ST_UNMARKED;
               state_in  = S_DONE;
            end else begin
               mark_we  = 1'b1;
               mark_wa  = bp_ff;
               bsz_in   = node_q.size;
               units_in = units_ff - node_q.size;
               p_in     = rover_ff;
               state_in = S_RRD;
            end
         end

         S_RRD: begin
            node_re  = 1'b1;
            node_ra  = p_ff[AW-1:0];
            state_in = S_RCHK;
         end

         // Find the free node below the block in address order.
         S_RCHK: begin
            if (walk_end ||
                ((bp13 > p_ff) && (bp13 < cur_link)) ||
                ((p_ff >= cur_link) && ((bp13 > p_ff) || (bp13 < cur_link)))) begin
               psz_in   = cur_sz;
               pn_in    = cur_link;
               node_re  = 1'b1;
               node_ra  = cur_link[AW-1:0];
               state_in = S_RPN;
            end else begin
               p_in     = cur_link;
               steps_in = steps_ff + UW'(1);
               state_in = S_RRD;
            end
         end

         // Link the block to its upper neighbor, merging if adjacent.
         S_RPN: begin
            node_we = 1'b1;
            node_wa = bp_ff;
            if (merge_hi) begin
               node_wd.size = bsz_ff + node_q.size;
               node_wd.link = node_q.link;
            end else begin
               node_wd.size = bsz_ff;
               node_wd.link = pn_ff;
            end
            bsz_in   = node_wd.size;
            pn_in    = node_wd.link;
            state_in = S_RLO;
         end

         // Link the lower neighbor to the block, merging if adjacent.
         S_RLO: begin
            rover_in = p_ff;
            if (merge_lo) begin
               node_we      = 1'b1;
               node_wa      = p_ff[AW-1:0];
               node_wd.size = psz_ff + bsz_ff;
               node_wd.link = pn_ff;
            end else if (p_ff == ffha_pkg::SENT) begin
               sent_in = bp13;
            end else begin
               node_we      = 1'b1;
               node_wa      = p_ff[AW-1:0];
               node_wd.size = psz_ff;
               node_wd.link = bp13;
            end
            state_in = S_DONE;
         end

         // Hold the result until the output register can take it.
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A pool write starts the heap over.
      if (reinit) begin
         state_in = S_CLEAR;
         clr_in   = '0;
         rover_in = ffha_pkg::SENT;
         sent_in  = '0;
         units_in = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         rover_ff <= ffha_pkg::SENT;
         sent_ff  <= '0;
         units_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rover_ff <= rover_in;
         sent_ff  <= sent_in;
         units_ff <= units_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      prev_ff    <= prev_in;
      prev_sz_ff <= prev_sz_in;
      psz_ff     <= psz_in;
      pn_ff      <= pn_in;
      bsz_ff     <= bsz_in;
      need_ff    <= need_in;
      bp_ff      <= bp_in;
      q_ff       <= q_in;
      steps_ff   <= steps_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   assign idle           = (state_ff == S_IDLE);
   assign done           = (state_ff == S_DONE);
   assign result.status  = status_ff;
   assign result.granted = granted_ff;
   assign result.units   = units_ff;

endmodule

`default_nettype wire

[sv/first_fit_heap_allocator_core.sv]
// First-fit heap allocator: request and result ports, pool register, output register.
// Depends on ffha_pkg and ffha_engine.
//
// Allocates and releases blocks of 8-byte units from a 4096-unit heap kept as an
// address-ordered circular free list with a roving search start. One item is
// worked at a time. The work for an allocate or a release grows with the number
// of free-list nodes visited, and so with fragmentation: each node costs one
// read of the header memory and one check of its registered data. An unmarked
// release answers without walking the free list. After reset and after every
// write of pool_units the block clears every allocated mark, with the request
// port stalled. A new request is taken while the previous result still waits
// in the output register.
`default_nettype none

module first_fit_heap_allocator_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel.
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_op,
   input  wire logic [ffha_pkg::BYTES_W-1:0]  req_request_bytes,
   input  wire logic [ffha_pkg::ADDR_W-1:0]   req_block_addr,
   // Result channel.
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [ffha_pkg::ADDR_W-1:0]        rsp_granted_addr,
   output logic [ffha_pkg::UNIT_W-1:0]        rsp_allocated_units,
   // Pool size register.
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ffha_pkg::UNIT_W-1:0]   csr_pool_units
);

   logic                              pool_wr, req_take, eng_idle, eng_done, out_free;
   logic [ffha_pkg::UNIT_W-1:0]       pool_ff, pool_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   ffha_pkg::result_type              eng_result, rsp_ff;

   // Pool register, saturated to the legal range.
   assign csr_ready = 1'b1;
   assign pool_wr   = csr_valid && csr_ready;

   always_comb begin
      pool_in = pool_ff;
      if (pool_wr) begin
         if (csr_pool_units < ffha_pkg::POOL_MIN) begin
            pool_in = ffha_pkg::POOL_MIN;
         end else if (csr_pool_units > ffha_pkg::POOL_MAX) begin
            pool_in = ffha_pkg::POOL_MAX;
         end else begin
            pool_in = csr_pool_units;
         end
      end
   end

   // Requests enter only when the engine is idle.
   assign req_stall = !eng_idle;
   assign req_take  = req_valid && !req_stall;

   ffha_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .reinit        (pool_wr),
      .pool_units    (pool_ff),
      .start         (req_take),
      .op            (req_op),
      .request_bytes (req_request_bytes),
      .block_addr    (req_block_addr),
      .out_free      (out_free),
      .idle          (eng_idle),
      .done          (eng_done),
      .result        (eng_result)
   );

   // Output register.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (eng_done && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff      <= ffha_pkg::POOL_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_done && out_free) begin
         rsp_ff <= eng_result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_granted_addr    = rsp_ff.granted;
   assign rsp_allocated_units = rsp_ff.units;

   // A pool write starts the clearing pass, so requests stall right after it.
   assert property (@(posedge clock) disable iff (reset)
      pool_wr |=> req_stall)
      else $error("request port open right after a pool write");

   // A failed item never carries a grant.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_ff.status != ffha_pkg::ST_OK) |-> (rsp_granted_addr == '0))
      else $error("failure result carries a granted address");

   // The status code is always one of the three defined codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3))
      else $error("undefined status code on result");

   // A request is never taken while a result waits in the engine.
   assert property (@(posedge clock) disable iff (reset)
      eng_done |-> req_stall)
      else $error("request port open while engine holds a result");

endmodule

`default_nettype wire
